@@ rtl/rst_pkg.sv @@
// package for the reference slot table: codes, field structs and default sizes
`timescale 1ns / 1ps
`default_nettype none
package rst_pkg;

    localparam int SLOTS_DEFAULT        = 64;
    localparam int OBJECT_WIDTH_DEFAULT = 32;
    localparam int OBJ_PORT_W           = 32;
    localparam int IDX_PORT_W           = 8;
    localparam int REF_OUT_W            = 7;
    localparam int MARK_W               = 64;

    localparam logic signed [REF_OUT_W-1:0]  NIL_REF_OUT = -7'sd2;
    localparam logic signed [IDX_PORT_W-1:0] NIL_REF_IN  = -8'sd2;

    typedef enum logic [1:0] {
        ACT_REF   = 2'd0,
        ACT_UNREF = 2'd1,
        ACT_GET   = 2'd2,
        ACT_SWEEP = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        RES_OK      = 2'd0,
        RES_FULL    = 2'd1,
        RES_INVALID = 2'd2
    } t_result;

    typedef enum logic [1:0] {
        ST_FREE      = 2'd0,
        ST_LOCKED    = 2'd1,
        ST_HELD      = 2'd2,
        ST_COLLECTED = 2'd3
    } t_slot_state;

    typedef struct packed {
        t_action                        action;
        logic [OBJ_PORT_W-1:0]          object_value;
        logic                           object_is_nil;
        logic                           lock_flag;
        logic signed [IDX_PORT_W-1:0]   ref_index;
        logic [MARK_W-1:0]              mark_bits;
    } t_cmd;

    typedef struct packed {
        logic signed [REF_OUT_W-1:0]    ref_out;
        t_result                        result_status;
        logic [OBJ_PORT_W-1:0]          object_out;
        logic                           object_out_nil;
    } t_rsp;

endpackage
`default_nettype wire

@@ rtl/reference_slot_table_top.sv @@
// reference slot table: status flops, object ram, one transaction per cycle
//
//  channel   signals            direction  transaction at
//  command   start, i_cmd       in         rising edge with start high and busy low
//  response  o_done, o_rsp      out        rising edge ending the cycle o_done is high
//
//  a command is taken in any cycle; busy stays low
//  its response shows in the next cycle, for one cycle, set by the registered object ram read
//  sustained rate is one command per cycle
//  synchronous reset frees every slot at once; the object ram is not cleared
//  the receiver cannot stall, so no response is ever held
`timescale 1ns / 1ps
`default_nettype none
module reference_slot_table_top
    import rst_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEFAULT,
    parameter int OBJECT_WIDTH = OBJECT_WIDTH_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_cmd i_cmd,
    output logic      busy,
    output logic      o_done,
    output t_rsp      o_rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_PORT_W-1:0] SLOTS_LIM = IDX_PORT_W'(SLOTS);

    t_slot_state             r_state [SLOTS];
    t_slot_state             n_state [SLOTS];
    logic [OBJECT_WIDTH-1:0] mem [SLOTS];
    logic [OBJECT_WIDTH-1:0] r_rd;

    logic                    r_done;
    t_action                 r_act;
    t_result                 r_res;
    logic                    r_nil_ref;
    logic                    r_nil_obj;
    logic                    r_get_ok;
    logic [IDX_W-1:0]        r_ref_idx;

    logic                    accept;
    logic                    in_range;
    logic [IDX_W-1:0]        cmd_idx;
    logic                    found;
    logic [IDX_W-1:0]        free_idx;
    logic                    get_ok;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_addr;
    t_result                 n_res;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign cmd_idx  = i_cmd.ref_index[IDX_W-1:0];
    assign in_range = !i_cmd.ref_index[IDX_PORT_W-1]
                      && ($unsigned(i_cmd.ref_index) < SLOTS_LIM);

    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_state[i] == ST_FREE) begin
                found    = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign get_ok = in_range
                    && (r_state[cmd_idx] == ST_LOCKED || r_state[cmd_idx] == ST_HELD);

    assign mem_we   = accept && (i_cmd.action == ACT_REF) && !i_cmd.object_is_nil && found;
    assign mem_addr = (i_cmd.action == ACT_REF) ? free_idx : cmd_idx;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            n_state[i] = r_state[i];
        end
        n_res = RES_OK;
        unique case (i_cmd.action)
            ACT_REF: begin
                if (!i_cmd.object_is_nil) begin
                    if (found) begin
                        n_state[free_idx] = i_cmd.lock_flag ? ST_LOCKED : ST_HELD;
                    end else begin
                        n_res = RES_FULL;
                    end
                end
            end
            ACT_UNREF: begin
                if (in_range) begin
                    n_state[cmd_idx] = ST_FREE;
                end
            end
            ACT_GET: begin
                if (i_cmd.ref_index != NIL_REF_IN && !get_ok) begin
                    n_res = RES_INVALID;
                end
            end
            ACT_SWEEP: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (r_state[i] == ST_HELD && !i_cmd.mark_bits[i]) begin
                        n_state[i] = ST_COLLECTED;
                    end
                end
            end
            default: begin
                n_res = RES_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= OBJECT_WIDTH'(i_cmd.object_value);
        end else begin
            r_rd <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_state[i] <= ST_FREE;
            end
            r_done <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                for (int i = 0; i < SLOTS; i++) begin
                    r_state[i] <= n_state[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act     <= i_cmd.action;
            r_res     <= n_res;
            r_ref_idx <= free_idx;
            r_nil_ref <= (i_cmd.action == ACT_REF) && i_cmd.object_is_nil;
            r_nil_obj <= (i_cmd.action == ACT_GET) && (i_cmd.ref_index == NIL_REF_IN);
            r_get_ok  <= (i_cmd.action == ACT_GET) && (i_cmd.ref_index != NIL_REF_IN)
                         && get_ok;
        end
    end

    always_comb begin
        o_rsp                = '0;
        o_rsp.result_status  = r_res;
        o_rsp.object_out_nil = r_nil_obj;
        if (r_act == ACT_REF && r_res == RES_OK) begin
            o_rsp.ref_out = r_nil_ref ? NIL_REF_OUT : REF_OUT_W'(r_ref_idx);
        end
        if (r_get_ok) begin
            o_rsp.object_out = OBJ_PORT_W'(r_rd);
        end
    end

    assign o_done = r_done;

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("response missing after a command");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy))
        else $error("response without a command");

    a_claimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_act == ACT_REF && r_res == RES_OK && !r_nil_ref)
            |-> (r_state[r_ref_idx] == ST_LOCKED || r_state[r_ref_idx] == ST_HELD))
        else $error("claimed slot not taken");

    a_full_only_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_res == RES_FULL) |-> (r_act == ACT_REF && !r_nil_ref))
        else $error("table full on a non-ref command");

    a_nil_obj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.object_out_nil)
            |-> (o_rsp.object_out == '0 && o_rsp.result_status == RES_OK))
        else $error("nil object with data or error");

endmodule
`default_nettype wire
